@@ sv/vlc_pkg.sv @@
// Shared types, constants and step codes for the vision landing controller.
`default_nettype none
package vlc_pkg;

  localparam int unsigned SETTLE_TICKS   = 20;
  localparam int unsigned LOST_TICKS     = 30;
  localparam int unsigned ADJUST_TICKS   = 30;
  localparam int unsigned CENTER_DESCENT = 200;
  localparam int unsigned SEARCH_CLIMB   = 200;
  localparam int unsigned ROOT_STEPS     = 30;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  // Register indexes
  localparam logic [2:0] REG_GAIN_H    = 3'd0;
  localparam logic [2:0] REG_GAIN_V    = 3'd1;
  localparam logic [2:0] REG_LIMIT_H   = 3'd2;
  localparam logic [2:0] REG_LIMIT_V   = 3'd3;
  localparam logic [2:0] REG_RADIUS    = 3'd4;
  localparam logic [2:0] REG_LAND_H    = 3'd5;
  localparam logic [2:0] REG_FLOOR_H   = 3'd6;
  localparam logic [2:0] REG_CEILING_H = 3'd7;

  // Datapath step codes
  localparam logic [3:0] OP_NONE = 4'd0;
  localparam logic [3:0] OP_OX2  = 4'd1;
  localparam logic [3:0] OP_OY2  = 4'd2;
  localparam logic [3:0] OP_ALT2 = 4'd3;
  localparam logic [3:0] OP_N    = 4'd4;
  localparam logic [3:0] OP_ROOT = 4'd5;
  localparam logic [3:0] OP_REF  = 4'd6;
  localparam logic [3:0] OP_GA   = 4'd7;
  localparam logic [3:0] OP_PX   = 4'd8;
  localparam logic [3:0] OP_PY   = 4'd9;
  localparam logic [3:0] OP_P1   = 4'd10;
  localparam logic [3:0] OP_P2   = 4'd11;
  localparam logic [3:0] OP_P3   = 4'd12;
  localparam logic [3:0] OP_PV   = 4'd13;
  localparam logic [3:0] OP_FIN  = 4'd14;

  typedef struct packed {
    logic [15:0] gain_horizontal;
    logic [15:0] gain_vertical;
    logic [11:0] speed_limit_horizontal;
    logic [11:0] speed_limit_vertical;
    logic [13:0] center_radius;
    logic [13:0] land_height;
    logic [13:0] floor_height;
    logic [13:0] ceiling_height;
  } cfg_t;

  typedef struct packed {
    logic       load;
    logic [3:0] op;
    logic       commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

@@ sv/vlc_tick_if.sv @@
// Request channel carrying one control tick.
`default_nettype none
interface vlc_tick_if;
  logic               valid;
  logic               ready;
  logic               stale;
  logic               detected;
  logic signed [15:0] offset_x;
  logic signed [15:0] offset_y;
  logic [13:0]        altitude;

  modport source (output valid, stale, detected, offset_x, offset_y, altitude, input ready);
  modport sink (input valid, stale, detected, offset_x, offset_y, altitude, output ready);
endinterface
`default_nettype wire

@@ sv/vlc_cmd_if.sv @@
// Request channel carrying one velocity command.
`default_nettype none
interface vlc_cmd_if;
  logic               valid;
  logic               ready;
  logic               speed_valid;
  logic signed [12:0] speed_x;
  logic signed [12:0] speed_y;
  logic signed [12:0] speed_z;
  logic               land;

  modport source (output valid, speed_valid, speed_x, speed_y, speed_z, land, input ready);
  modport sink (input valid, speed_valid, speed_x, speed_y, speed_z, land, output ready);
endinterface
`default_nettype wire

@@ sv/vlc_regs.sv @@
// APB configuration register bank.
`default_nettype none
module vlc_regs import vlc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_horizontal        <= 16'd1229;
      cfg.gain_vertical          <= 16'd1229;
      cfg.speed_limit_horizontal <= 12'd300;
      cfg.speed_limit_vertical   <= 12'd300;
      cfg.center_radius          <= 14'd400;
      cfg.land_height            <= 14'd1100;
      cfg.floor_height           <= 14'd1000;
      cfg.ceiling_height         <= 14'd8000;
    end else if (wr) begin
      case (idx)
        REG_GAIN_H:    cfg.gain_horizontal        <= pwdata[15:0];
        REG_GAIN_V:    cfg.gain_vertical          <= pwdata[15:0];
        REG_LIMIT_H:   cfg.speed_limit_horizontal <= pwdata[11:0];
        REG_LIMIT_V:   cfg.speed_limit_vertical   <= pwdata[11:0];
        REG_RADIUS:    cfg.center_radius          <= pwdata[13:0];
        REG_LAND_H:    cfg.land_height            <= pwdata[13:0];
        REG_FLOOR_H:   cfg.floor_height           <= pwdata[13:0];
        REG_CEILING_H: cfg.ceiling_height         <= pwdata[13:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_GAIN_H:    prdata = {16'd0, cfg.gain_horizontal};
      REG_GAIN_V:    prdata = {16'd0, cfg.gain_vertical};
      REG_LIMIT_H:   prdata = {20'd0, cfg.speed_limit_horizontal};
      REG_LIMIT_V:   prdata = {20'd0, cfg.speed_limit_vertical};
      REG_RADIUS:    prdata = {18'd0, cfg.center_radius};
      REG_LAND_H:    prdata = {18'd0, cfg.land_height};
      REG_FLOOR_H:   prdata = {18'd0, cfg.floor_height};
      REG_CEILING_H: prdata = {18'd0, cfg.ceiling_height};
      default:       prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

@@ sv/vlc_ctrl.sv @@
// Step sequencer for the landing controller datapath.
`default_nettype none
module vlc_ctrl import vlc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic       state;
  logic       state_next;
  logic [3:0] op;
  logic [3:0] op_next;
  logic [4:0] count;
  logic [4:0] count_next;

  assign in_ready   = (state == ST_IDLE);
  assign cmd.load   = in_ready && in_valid;
  assign cmd.op     = (state == ST_RUN) ? op : OP_NONE;
  assign cmd.commit = (state == ST_RUN) && (op == OP_FIN) && status.out_free;

  always_comb begin
    state_next = state;
    op_next    = op;
    count_next = count;
    if (state == ST_IDLE) begin
      if (cmd.load) begin
        state_next = ST_RUN;
        op_next    = OP_OX2;
      end
    end else begin
      case (op)
        OP_OX2:  op_next = OP_OY2;
        OP_OY2:  op_next = OP_ALT2;
        OP_ALT2: op_next = OP_N;
        OP_N: begin
          op_next    = OP_ROOT;
          count_next = '0;
        end
        OP_ROOT: begin
          count_next = count + 5'd1;
          if (count == 5'(ROOT_STEPS - 1)) op_next = OP_REF;
        end
        OP_REF:  op_next = OP_GA;
        OP_GA:   op_next = OP_PX;
        OP_PX:   op_next = OP_PY;
        OP_PY:   op_next = OP_P1;
        OP_P1:   op_next = OP_P2;
        OP_P2:   op_next = OP_P3;
        OP_P3:   op_next = OP_PV;
        OP_PV:   op_next = OP_FIN;
        OP_FIN: begin
          if (status.out_free) begin
            state_next = ST_IDLE;
            op_next    = OP_NONE;
          end
        end
        default: begin
          state_next = ST_IDLE;
          op_next    = OP_NONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      op    <= OP_NONE;
      count <= '0;
    end else begin
      state <= state_next;
      op    <= op_next;
      count <= count_next;
    end
  end

endmodule
`default_nettype wire

@@ sv/vlc_dp.sv @@
// Shared-multiplier datapath, square root, tick state and result register.
`default_nettype none
module vlc_dp import vlc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  ctrl_cmd_t          cmd,
  output dp_status_t         status,
  input  logic               stale,
  input  logic               detected,
  input  logic signed [15:0] offset_x,
  input  logic signed [15:0] offset_y,
  input  logic [13:0]        altitude,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               speed_valid,
  output logic signed [12:0] speed_x,
  output logic signed [12:0] speed_y,
  output logic signed [12:0] speed_z,
  output logic               land
);

  function automatic logic signed [12:0] signed_mag(input logic neg, input logic [11:0] mag);
    logic signed [12:0] v;
    v = $signed({1'b0, mag});
    return neg ? -v : v;
  endfunction

  // Captured request
  logic        in_stale, in_det, ox_neg, oy_neg;
  logic [15:0] ox_mag, oy_mag;
  logic [13:0] alt;

  // Intermediate products
  logic [31:0] sq;
  logic [27:0] alt2;
  logic [59:0] rad;
  logic [32:0] rem;
  logic [29:0] root;
  logic [15:0] distance, ds;
  logic [13:0] hs_mag;
  logic        hs_neg;
  logic [29:0] ga, p1, p2, p3;
  logic [19:0] px, py;
  logic [17:0] pv;

  // Tick state
  logic        first_seen, landed;
  logic [15:0] start_distance;
  logic [13:0] start_altitude;
  logic [7:0]  settle_count, lost_count;
  logic [5:0]  adjust_count;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;

  logic signed [14:0] hc, hs_cur;
  logic [13:0]        hc_mag;
  logic               first_now;

  assign status.out_free = !out_valid || out_ready;

  assign hc        = $signed({1'b0, alt}) - $signed({1'b0, cfg.floor_height});
  assign hc_mag    = hc[14] ? 14'(-hc) : hc[13:0];
  assign first_now = in_det && !first_seen;
  assign hs_cur    = $signed({1'b0, (first_now ? alt : start_altitude)}) -
                     $signed({1'b0, cfg.floor_height});

  always_comb begin
    case (cmd.op)
      OP_OX2:  begin mul_a = 32'(ox_mag);              mul_b = 32'(ox_mag); end
      OP_OY2:  begin mul_a = 32'(oy_mag);              mul_b = 32'(oy_mag); end
      OP_ALT2: begin mul_a = 32'(alt);                 mul_b = 32'(alt); end
      OP_N:    begin mul_a = 32'(alt2);                mul_b = sq; end
      OP_GA:   begin mul_a = 32'(cfg.gain_horizontal); mul_b = 32'(alt); end
      OP_PX:   begin mul_a = 32'(ga);                  mul_b = 32'(ox_mag); end
      OP_PY:   begin mul_a = 32'(ga);                  mul_b = 32'(oy_mag); end
      OP_P1:   begin mul_a = 32'(distance);            mul_b = 32'(hs_mag); end
      OP_P2:   begin mul_a = 32'(hc_mag);              mul_b = 32'(ds); end
      OP_P3:   begin mul_a = 32'(ds);                  mul_b = 32'(hs_mag); end
      OP_PV:   begin mul_a = 32'(cfg.gain_vertical);   mul_b = 32'(hc_mag); end
      default: begin mul_a = '0;                       mul_b = '0; end
    endcase
  end

  assign prod = 64'(mul_a) * 64'(mul_b);

  // Root step
  logic [32:0] rem_sh;
  logic [32:0] trial;
  assign rem_sh = {rem[30:0], rad[59:58]};
  assign trial  = {1'b0, root, 2'b01};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_stale <= stale;
      in_det   <= detected;
      ox_neg   <= offset_x[15];
      oy_neg   <= offset_y[15];
      ox_mag   <= offset_x[15] ? 16'(-offset_x) : offset_x;
      oy_mag   <= offset_y[15] ? 16'(-offset_y) : offset_y;
      alt      <= altitude;
    end
    case (cmd.op)
      OP_OX2:  sq   <= prod[31:0];
      OP_OY2:  sq   <= sq + prod[31:0];
      OP_ALT2: alt2 <= prod[27:0];
      OP_N: begin
        rad  <= prod[59:0];
        rem  <= '0;
        root <= '0;
      end
      OP_ROOT: begin
        rad <= {rad[57:0], 2'b00};
        if (rem_sh >= trial) begin
          rem  <= rem_sh - trial;
          root <= {root[28:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          root <= {root[28:0], 1'b0};
        end
      end
      OP_REF: begin
        distance <= root[29:14];
        ds       <= first_now ? root[29:14] : start_distance;
        hs_neg   <= hs_cur[14];
        hs_mag   <= hs_cur[14] ? 14'(-hs_cur) : hs_cur[13:0];
      end
      OP_GA: ga <= prod[29:0];
      OP_PX: px <= prod[45:26];
      OP_PY: py <= prod[45:26];
      OP_P1: p1 <= prod[29:0];
      OP_P2: p2 <= prod[29:0];
      OP_P3: p3 <= prod[29:0];
      OP_PV: pv <= prod[29:12];
      default: ;
    endcase
  end

  // Decision for the finished tick
  logic signed [32:0] t1, t2, num;
  logic [31:0]        an;
  logic [35:0]        an10;
  logic               mismatch, climb, near, vneg;
  logic [11:0]        vx_mag, vy_mag, vz_mag;
  logic [5:0]         adjust_inc;

  logic               r_valid, r_land;
  logic signed [12:0] r_x, r_y, r_z;
  logic               first_seen_next, landed_next;
  logic [15:0]        start_distance_next;
  logic [13:0]        start_altitude_next;
  logic [7:0]         settle_next, lost_next;
  logic [5:0]         adjust_next;

  always_comb begin
    t1       = $signed({3'b0, p1});
    t2       = $signed({3'b0, p2});
    num      = (hs_neg ? -t1 : t1) - (hc[14] ? -t2 : t2);
    an       = num[32] ? 32'(-num) : num[31:0];
    an10     = {an, 3'b000} + {3'b000, an, 1'b0};
    mismatch = an10 > 36'(p3);
    climb    = (hs_neg && ds != 16'd0) ? num[32] : (!num[32] && num != '0);
    near     = distance <= {2'b00, cfg.center_radius};

    vx_mag = (px > 20'(cfg.speed_limit_horizontal)) ? cfg.speed_limit_horizontal : px[11:0];
    vy_mag = (py > 20'(cfg.speed_limit_horizontal)) ? cfg.speed_limit_horizontal : py[11:0];
    if (pv > 18'(cfg.speed_limit_vertical)) begin
      vz_mag = cfg.speed_limit_vertical;
      vneg   = !climb;
    end else begin
      vz_mag = pv[11:0];
      vneg   = climb ? hc[14] : !hc[14];
    end
    adjust_inc = (adjust_count == 6'd63) ? adjust_count : adjust_count + 6'd1;

    r_valid             = 1'b0;
    r_x                 = '0;
    r_y                 = '0;
    r_z                 = '0;
    first_seen_next     = first_seen;
    landed_next         = landed;
    start_distance_next = start_distance;
    start_altitude_next = start_altitude;
    settle_next         = settle_count;
    lost_next           = lost_count;
    adjust_next         = adjust_count;

    if (!landed && in_stale) begin
      r_valid = 1'b1;
    end else if (!landed) begin
      if (in_det) begin
        if (!first_seen) begin
          start_distance_next = distance;
          start_altitude_next = alt;
          first_seen_next     = 1'b1;
        end
        lost_next = '0;
        r_valid   = 1'b1;
        if (!near) begin
          settle_next = '0;
          r_x = signed_mag(ox_neg, vx_mag);
          r_y = signed_mag(oy_neg, vy_mag);
          if (mismatch) begin
            adjust_next = adjust_inc;
            if (adjust_inc > 6'(ADJUST_TICKS)) r_z = signed_mag(vneg, vz_mag);
          end else begin
            adjust_next = '0;
          end
        end else begin
          settle_next = (settle_count == 8'd255) ? settle_count : settle_count + 8'd1;
          r_z         = -$signed(13'(CENTER_DESCENT));
        end
      end else begin
        lost_next   = (lost_count == 8'd255) ? lost_count : lost_count + 8'd1;
        settle_next = '0;
        if (lost_next > 8'(LOST_TICKS)) begin
          r_valid = 1'b1;
          if (alt <= cfg.ceiling_height) r_z = 13'(SEARCH_CLIMB);
        end
      end
      if (near && settle_next > 8'(SETTLE_TICKS) && alt <= cfg.land_height) landed_next = 1'b1;
    end
    r_land = landed_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_seen     <= 1'b0;
      landed         <= 1'b0;
      start_distance <= '0;
      start_altitude <= '0;
      settle_count   <= '0;
      lost_count     <= '0;
      adjust_count   <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.commit) begin
        first_seen     <= first_seen_next;
        landed         <= landed_next;
        start_distance <= start_distance_next;
        start_altitude <= start_altitude_next;
        settle_count   <= settle_next;
        lost_count     <= lost_next;
        adjust_count   <= adjust_next;
        out_valid      <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      speed_valid <= r_valid;
      speed_x     <= r_x;
      speed_y     <= r_y;
      speed_z     <= r_z;
      land        <= r_land;
    end
  end

endmodule
`default_nettype wire

@@ sv/vision_landing_controller.sv @@
// Top level of the vision landing controller.
//
// Usage: one request on "tick" per control tick (stale, detected, pad offsets,
// altitude) gives exactly one request on "command" (speed_valid, speeds, land).
// Both channels use valid/ready; a request moves when both are high.
// Registers are written over the APB port, one per 4-byte word; the user must
// write them only while idle, which the block itself does not enforce.
// One shared 32x32 multiplier serves 11 steps, and the square root makes one
// result bit per cycle. A new tick is taken only once the last one is through
// the final step; tick.ready is high only between ticks.
// A finished command sits in an output register; a new tick is accepted while
// it waits, and the next result holds in the final step until the register
// frees, so a stalled receiver backs up into tick.ready.
// Reset (rst, synchronous) restores register defaults and clears the tracking
// state: first sighting, counters and the sticky land flag.
`default_nettype none
module vision_landing_controller import vlc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  vlc_tick_if.sink          tick,
  vlc_cmd_if.source         command,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  vlc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  vlc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (tick.valid),
    .in_ready (tick.ready),
    .status   (status),
    .cmd      (cmd)
  );

  vlc_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd         (cmd),
    .status      (status),
    .stale       (tick.stale),
    .detected    (tick.detected),
    .offset_x    (tick.offset_x),
    .offset_y    (tick.offset_y),
    .altitude    (tick.altitude),
    .out_valid   (command.valid),
    .out_ready   (command.ready),
    .speed_valid (command.speed_valid),
    .speed_x     (command.speed_x),
    .speed_y     (command.speed_y),
    .speed_z     (command.speed_z),
    .land        (command.land)
  );

endmodule
`default_nettype wire
